@@ rtl/core/periodic_interrupt_timer_assert.svh @@
// assertion macros for the periodic interrupt timer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef PERIODIC_INTERRUPT_TIMER_ASSERT_SVH
`define PERIODIC_INTERRUPT_TIMER_ASSERT_SVH

// same-cycle implication
`define PIT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pit assertion failed");

// next-cycle implication
`define PIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pit assertion failed");

`endif

@@ rtl/core/pit_pkg.sv @@
// shared constants, codes and types of the periodic interrupt timer
// no dependencies
package pit_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_WIDTH  = 32;
    localparam int DATA_WIDTH   = 32;
    localparam int IRQ_WIDTH    = 4;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] SEL_LOAD   = 3'd0;
    localparam logic [2:0] SEL_COUNT  = 3'd1;
    localparam logic [2:0] SEL_CTRL   = 3'd2;
    localparam logic [2:0] SEL_FLAG   = 3'd3;
    localparam logic [2:0] SEL_MODULE = 3'd4;

    typedef struct packed {
        logic [1:0]            command;
        logic [1:0]            channel;
        logic [2:0]            register_select;
        logic [DATA_WIDTH-1:0] write_data;
    } pit_item_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } pit_stage_ctl_t;

endpackage

@@ rtl/core/pit_if.sv @@
// handshake channels of the periodic interrupt timer: request and response
// depends on pit_pkg
interface pit_req_if
    import pit_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [1:0]            command;
    logic [1:0]            channel;
    logic [2:0]            register_select;
    logic [DATA_WIDTH-1:0] write_data;

    modport source (output valid, command, channel, register_select, write_data, input ready);
    modport sink   (input valid, command, channel, register_select, write_data, output ready);
endinterface

interface pit_rsp_if
    import pit_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] read_data;
    logic [IRQ_WIDTH-1:0]  irq_lines;

    modport source (output valid, read_data, irq_lines, input ready);
    modport sink   (input valid, read_data, irq_lines, output ready);
endinterface

@@ rtl/core/pit_in_stage.sv @@
// input register of the timer: captures one request item
// depends on pit_pkg
module pit_in_stage
    import pit_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pit_item_t      in_item,
    input  logic           core_ready,
    output pit_stage_ctl_t ctl,
    output pit_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    pit_item_t item_reg;
    logic      advance;

    assign advance    = valid_reg && core_ready;
    assign in_ready   = !valid_reg || core_ready;
    assign valid_next = in_valid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

@@ rtl/core/pit_core.sv @@
// timer state, register access, tick handling and result register
// depends on pit_pkg
module pit_core
    import pit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pit_stage_ctl_t        ctl,
    input  pit_item_t             item,
    output logic                  core_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] read_data,
    output logic [IRQ_WIDTH-1:0]  irq_lines
);

    logic [COUNT_WIDTH-1:0]  load_reg  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  load_next [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  count_reg [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  count_next[NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] en_reg, en_next;
    logic [NUM_CHANNELS-1:0] ie_reg, ie_next;
    logic [NUM_CHANNELS-1:0] flag_reg, flag_next;
    logic                    disable_reg, disable_next;
    logic                    freeze_reg, freeze_next;

    logic                    valid_reg;
    logic [DATA_WIDTH-1:0]   rd_reg, rd_next;
    logic [IRQ_WIDTH-1:0]    irq_reg, irq_next;
    logic [NUM_CHANNELS+IRQ_WIDTH-1:0] irq_wide;

    logic is_read, is_write, is_tick;

    assign core_ready = !valid_reg || out_ready;
    assign is_read    = item.command == CMD_READ;
    assign is_write   = item.command == CMD_WRITE;
    assign is_tick    = item.command == CMD_TICK;

    always_comb
    begin
        logic hit;
        disable_next = disable_reg;
        freeze_next  = freeze_reg;
        en_next      = en_reg;
        ie_next      = ie_reg;
        flag_next    = flag_reg;
        rd_next      = '0;
        if (is_write && item.register_select == SEL_MODULE)
        begin
            disable_next = item.write_data[1];
            freeze_next  = item.write_data[0];
        end
        if (is_read && item.register_select == SEL_MODULE)
        begin
            rd_next = {{(DATA_WIDTH-2){1'b0}}, disable_reg, freeze_reg};
        end
        for (int n = 0; n < NUM_CHANNELS; n++)
        begin
            hit           = 32'(item.channel) == n;
            load_next[n]  = load_reg[n];
            count_next[n] = count_reg[n];
            if (is_tick && !disable_reg && en_reg[n])
            begin
                if (count_reg[n] == '0)
                begin
                    flag_next[n]  = 1'b1;
                    count_next[n] = load_reg[n];
                end
                else
                begin
                    count_next[n] = count_reg[n] - 1'b1;
                end
            end
            if (is_write && hit)
            begin
                case (item.register_select)
                    SEL_LOAD:
                    begin
                        load_next[n] = item.write_data[COUNT_WIDTH-1:0];
                    end
                    SEL_CTRL:
                    begin
                        if (item.write_data[0] && !en_reg[n])
                        begin
                            count_next[n] = load_reg[n];
                        end
                        en_next[n] = item.write_data[0];
                        ie_next[n] = item.write_data[1];
                    end
                    SEL_FLAG:
                    begin
                        if (item.write_data[0])
                        begin
                            flag_next[n] = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (is_read && hit)
            begin
                case (item.register_select)
                    SEL_LOAD:  rd_next = DATA_WIDTH'(load_reg[n]);
                    SEL_COUNT: rd_next = DATA_WIDTH'(count_reg[n]);
                    SEL_CTRL:  rd_next = {{(DATA_WIDTH-2){1'b0}}, ie_reg[n], en_reg[n]};
                    SEL_FLAG:  rd_next = {{(DATA_WIDTH-1){1'b0}}, flag_reg[n]};
                    default:   ;
                endcase
            end
        end
        irq_wide = {{IRQ_WIDTH{1'b0}}, flag_next & ie_next};
        irq_next = irq_wide[IRQ_WIDTH-1:0];
    end

    // architectural state moves only when an item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                load_reg[n]  <= '0;
                count_reg[n] <= '0;
            end
            en_reg      <= '0;
            ie_reg      <= '0;
            flag_reg    <= '0;
            disable_reg <= 1'b1;
            freeze_reg  <= 1'b0;
        end
        else if (ctl.advance)
        begin
            load_reg    <= load_next;
            count_reg   <= count_next;
            en_reg      <= en_next;
            ie_reg      <= ie_next;
            flag_reg    <= flag_next;
            disable_reg <= disable_next;
            freeze_reg  <= freeze_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (core_ready)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            rd_reg  <= rd_next;
            irq_reg <= irq_next;
        end
    end

    assign out_valid = valid_reg;
    assign read_data = rd_reg;
    assign irq_lines = irq_reg;

endmodule

@@ rtl/core/periodic_interrupt_timer.sv @@
// top level of the four-channel periodic interrupt timer
// depends on pit_pkg, pit_if, pit_in_stage and pit_core
//
//  channel  dir  payload                                          handshake
//  req      in   command, channel, register_select, write_data    valid/ready
//  rsp      out  read_data, irq_lines                             valid/ready
//
// one item per cycle sustained while rsp is ready; each response passes the input register, then the response register
// the state update happens as an item moves from the input register to the response register
// reset: module disabled, all channels stopped, flags and values cleared, no items held
// a stalled rsp holds its item; req stays ready until both registers are full
module periodic_interrupt_timer
    import pit_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    pit_req_if.sink   req,
    pit_rsp_if.source rsp
);

    pit_item_t      in_item;
    pit_item_t      item;
    pit_stage_ctl_t ctl;
    logic           core_ready;

    assign in_item.command         = req.command;
    assign in_item.channel         = req.channel;
    assign in_item.register_select = req.register_select;
    assign in_item.write_data      = req.write_data;

    pit_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_item    (in_item),
        .core_ready (core_ready),
        .ctl        (ctl),
        .item       (item)
    );

    pit_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .item       (item),
        .core_ready (core_ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .read_data  (rsp.read_data),
        .irq_lines  (rsp.irq_lines)
    );

endmodule

@@ rtl/core/pit_checker.sv @@
// port-level checker of the periodic interrupt timer, bound to the top level
// depends on pit_pkg and periodic_interrupt_timer_assert.svh
`include "periodic_interrupt_timer_assert.svh"

module pit_checker
    import pit_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [DATA_WIDTH-1:0] read_data,
    input logic [IRQ_WIDTH-1:0]  irq_lines
);

    logic [1:0] pending_reg;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, req_fire} - {1'b0, rsp_fire};
        end
    end

    `PIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(read_data) && $stable(irq_lines))
    `PIT_ASSERT_NOW(a_pending_bound, 1'b1, pending_reg != 2'd3)
    `PIT_ASSERT_NOW(a_rsp_has_item, rsp_valid, pending_reg != 2'd0)
    `PIT_ASSERT_NOW(a_full_blocks_req, pending_reg == 2'd2 && !rsp_ready, !req_ready)

endmodule

bind periodic_interrupt_timer pit_checker u_pit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .read_data (rsp.read_data),
    .irq_lines (rsp.irq_lines)
);
